// ----- design/rgb_histogram_equalizer_top_defines.svh -----
// assertion macros for the rgb histogram equalizer top level
// depends on nothing; included by rgb_histogram_equalizer_top.sv
`ifndef RGB_HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH
`define RGB_HISTOGRAM_EQUALIZER_TOP_DEFINES_SVH

// same-cycle implication
`define RGBHE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RGBHE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// condition that must never hold
`define RGBHE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- design/rgbhe_pkg.sv -----
// shared types and constants of the rgb histogram equalizer
// no dependencies
package rgbhe_pkg;

  localparam int NUM_BINS = 256;
  localparam int BIN_W    = 8;
  localparam int COUNT_W  = 23;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_COUNT = 3'd1,
    CMD_BUILD = 3'd2,
    CMD_MAP   = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_USE,
    S_B_RD,
    S_B_ACC,
    S_B_SET
  } state_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [BIN_W-1:0] pix_blue;
    logic [BIN_W-1:0] pix_green;
    logic [BIN_W-1:0] pix_red;
    logic [BIN_W-1:0] bin_index;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [BIN_W-1:0]   eq_blue;
    logic [BIN_W-1:0]   eq_green;
    logic [BIN_W-1:0]   eq_red;
    logic [COUNT_W-1:0] count_red;
    logic [COUNT_W-1:0] count_green;
    logic [COUNT_W-1:0] count_blue;
    logic [COUNT_W-1:0] count_gray;
  } out_t;

  typedef struct packed {
    logic start;
    logic acc;
    logic step;
    logic wr;
  } lane_ctl_t;

endpackage

// ----- design/rgb_histogram_equalizer_top.sv -----
// rgb histogram equalizer. one request a time: count reads the four bins
// and writes them back incremented, map and read wait on out_stall, and
// build walks the 256 bins in three color lanes: per bin a read, an
// accumulate and a set state, the set state repeating for each step that
// the slowest lane's quotient rises in that bin. each lane rises at most
// 255 steps over the whole walk. the read-modify-write of the histogram
// memories sets the count rate and the quotient search in the lanes sets
// the build time. clear is immediate through per-bin valid bits.
// maps hold garbage until a build.
// depends on rgbhe_pkg, rgbhe_hist, rgbhe_lane and the defines header
`include "rgb_histogram_equalizer_top_defines.svh"

module rgb_histogram_equalizer_top #(
  parameter int MAX_PIXELS = 4194304
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rgbhe_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rgbhe_pkg::out_t  out_data
);

  localparam int CW     = $clog2(MAX_PIXELS + 1);
  localparam int CountW = rgbhe_pkg::COUNT_W;
  localparam int BW     = rgbhe_pkg::BIN_W;

  rgbhe_pkg::state_t    state_r, state_nxt;
  rgbhe_pkg::in_t       req_r;
  rgbhe_pkg::out_t      out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        total_r;
  logic [BW-1:0]        bin_r;
  logic                 accept;
  logic                 building;
  logic                 is_read;
  logic                 is_count;
  logic                 is_map;
  logic                 clr;
  logic                 hist_rd_en;
  logic                 hist_wr_en;
  logic                 map_rd_en;
  logic                 load_out;
  logic                 any_busy;
  rgbhe_pkg::lane_ctl_t lane_ctl;
  logic [17:0]          gray_sum;
  logic [BW-1:0]        addr_red, addr_green, addr_blue, addr_gray;
  logic [CW-1:0]        rd_red, rd_green, rd_blue, rd_gray;
  logic [BW-1:0]        map_red, map_green, map_blue;
  logic                 busy_red, busy_green, busy_blue;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != rgbhe_pkg::S_IDLE);
  assign is_read  = (req_r.cmd == rgbhe_pkg::CMD_READ);
  assign is_count = (req_r.cmd == rgbhe_pkg::CMD_COUNT);
  assign is_map   = (req_r.cmd == rgbhe_pkg::CMD_MAP);
  assign building = (state_r == rgbhe_pkg::S_B_RD) || (state_r == rgbhe_pkg::S_B_ACC)
                 || (state_r == rgbhe_pkg::S_B_SET);

  // merge of the three lanes: a bin is done when no lane still climbs
  assign any_busy = busy_red || busy_green || busy_blue;

  // gray = (117b + 601g + 306r) >> 10
  assign gray_sum = 18'(req_r.pix_blue) * 18'd117 + 18'(req_r.pix_green) * 18'd601
                  + 18'(req_r.pix_red) * 18'd306;

  always_comb begin
    if (building) begin
      addr_red   = bin_r;
      addr_green = bin_r;
      addr_blue  = bin_r;
      addr_gray  = bin_r;
    end else if (is_read) begin
      addr_red   = req_r.bin_index;
      addr_green = req_r.bin_index;
      addr_blue  = req_r.bin_index;
      addr_gray  = req_r.bin_index;
    end else begin
      addr_red   = req_r.pix_red;
      addr_green = req_r.pix_green;
      addr_blue  = req_r.pix_blue;
      addr_gray  = gray_sum[17:10];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgbhe_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            rgbhe_pkg::CMD_COUNT: begin
              if (total_r < CW'(MAX_PIXELS)) begin
                state_nxt = rgbhe_pkg::S_RD;
              end
            end
            rgbhe_pkg::CMD_BUILD: state_nxt = rgbhe_pkg::S_B_RD;
            rgbhe_pkg::CMD_MAP:   state_nxt = rgbhe_pkg::S_RD;
            rgbhe_pkg::CMD_READ:  state_nxt = rgbhe_pkg::S_RD;
            default:              state_nxt = rgbhe_pkg::S_IDLE;
          endcase
        end
      end
      rgbhe_pkg::S_RD: state_nxt = rgbhe_pkg::S_USE;
      rgbhe_pkg::S_USE: begin
        if (is_count || !out_valid_r || !out_stall) begin
          state_nxt = rgbhe_pkg::S_IDLE;
        end
      end
      rgbhe_pkg::S_B_RD:  state_nxt = rgbhe_pkg::S_B_ACC;
      rgbhe_pkg::S_B_ACC: state_nxt = rgbhe_pkg::S_B_SET;
      rgbhe_pkg::S_B_SET: begin
        if (!any_busy) begin
          state_nxt = (bin_r == '1) ? rgbhe_pkg::S_IDLE : rgbhe_pkg::S_B_RD;
        end
      end
      default: state_nxt = rgbhe_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    clr        = 1'b0;
    hist_rd_en = 1'b0;
    hist_wr_en = 1'b0;
    map_rd_en  = 1'b0;
    load_out   = 1'b0;
    lane_ctl   = '0;
    case (state_r)
      rgbhe_pkg::S_IDLE: begin
        clr            = accept && (in_data.cmd == rgbhe_pkg::CMD_CLEAR);
        lane_ctl.start = accept && (in_data.cmd == rgbhe_pkg::CMD_BUILD);
      end
      rgbhe_pkg::S_RD: begin
        hist_rd_en = is_count || is_read;
        map_rd_en  = is_map;
      end
      rgbhe_pkg::S_USE: begin
        hist_wr_en = is_count;
        load_out   = !is_count && (!out_valid_r || !out_stall);
      end
      rgbhe_pkg::S_B_RD:  hist_rd_en   = 1'b1;
      rgbhe_pkg::S_B_ACC: lane_ctl.acc = 1'b1;
      rgbhe_pkg::S_B_SET: begin
        lane_ctl.step = 1'b1;
        lane_ctl.wr   = !any_busy;
      end
      default: ;
    endcase
  end

  // result assembly; unused fields are zero
  always_comb begin
    out_nxt = '0;
    if (is_read) begin
      out_nxt.result_kind = 1'b1;
      out_nxt.count_red   = CountW'(rd_red);
      out_nxt.count_green = CountW'(rd_green);
      out_nxt.count_blue  = CountW'(rd_blue);
      out_nxt.count_gray  = CountW'(rd_gray);
    end else begin
      out_nxt.eq_blue  = map_blue;
      out_nxt.eq_green = map_green;
      out_nxt.eq_red   = map_red;
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgbhe_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      bin_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr) begin
        total_r <= '0;
      end else if (hist_wr_en) begin
        total_r <= total_r + 1'b1;
      end
      if (lane_ctl.start) begin
        bin_r <= '0;
      end else if (lane_ctl.wr) begin
        bin_r <= bin_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rgbhe_hist #(.CW(CW)) u_hist_red (
    .clk(clk), .rst_n(rst_n), .clr(clr), .rd_en(hist_rd_en), .rd_addr(addr_red),
    .wr_en(hist_wr_en), .wr_addr(addr_red), .wr_data(rd_red + 1'b1), .rd_data(rd_red)
  );

  rgbhe_hist #(.CW(CW)) u_hist_green (
    .clk(clk), .rst_n(rst_n), .clr(clr), .rd_en(hist_rd_en), .rd_addr(addr_green),
    .wr_en(hist_wr_en), .wr_addr(addr_green), .wr_data(rd_green + 1'b1),
    .rd_data(rd_green)
  );

  rgbhe_hist #(.CW(CW)) u_hist_blue (
    .clk(clk), .rst_n(rst_n), .clr(clr), .rd_en(hist_rd_en), .rd_addr(addr_blue),
    .wr_en(hist_wr_en), .wr_addr(addr_blue), .wr_data(rd_blue + 1'b1), .rd_data(rd_blue)
  );

  rgbhe_hist #(.CW(CW)) u_hist_gray (
    .clk(clk), .rst_n(rst_n), .clr(clr), .rd_en(hist_rd_en), .rd_addr(addr_gray),
    .wr_en(hist_wr_en), .wr_addr(addr_gray), .wr_data(rd_gray + 1'b1), .rd_data(rd_gray)
  );

  rgbhe_lane #(.CW(CW)) u_lane_red (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .total(total_r), .hist_data(rd_red),
    .bin(bin_r), .map_rd_en(map_rd_en), .map_rd_addr(req_r.pix_red),
    .map_rd_data(map_red), .busy(busy_red)
  );

  rgbhe_lane #(.CW(CW)) u_lane_green (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .total(total_r), .hist_data(rd_green),
    .bin(bin_r), .map_rd_en(map_rd_en), .map_rd_addr(req_r.pix_green),
    .map_rd_data(map_green), .busy(busy_green)
  );

  rgbhe_lane #(.CW(CW)) u_lane_blue (
    .clk(clk), .rst_n(rst_n), .ctl(lane_ctl), .total(total_r), .hist_data(rd_blue),
    .bin(bin_r), .map_rd_en(map_rd_en), .map_rd_addr(req_r.pix_blue),
    .map_rd_data(map_blue), .busy(busy_blue)
  );

  // checks
  `RGBHE_ASSERT_NEVER(a_total_cap, clk, rst_n, total_r > CW'(MAX_PIXELS), "pixel total past cap")
  `RGBHE_ASSERT_NXT(a_count_inc, clk, rst_n, hist_wr_en, total_r == $past(total_r) + 1'b1, "count lost")
  `RGBHE_ASSERT_IMP(a_map_zero, clk, rst_n, out_valid_r && !out_r.result_kind, out_r.count_red == '0 && out_r.count_gray == '0, "map result with counts")
  `RGBHE_ASSERT_IMP(a_wr_settled, clk, rst_n, lane_ctl.wr, !busy_red && !busy_green && !busy_blue, "map written while lane busy")

endmodule

// ----- design/rgbhe_hist.sv -----
// one histogram: 256-bin count memory with per-bin valid bits for a clear of all bins at once
// depends on rgbhe_pkg
module rgbhe_hist #(
  parameter int CW = 23
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  logic                         rd_en,
  input  logic [rgbhe_pkg::BIN_W-1:0]  rd_addr,
  input  logic                         wr_en,
  input  logic [rgbhe_pkg::BIN_W-1:0]  wr_addr,
  input  logic [CW-1:0]                wr_data,
  output logic [CW-1:0]                rd_data
);

  logic [CW-1:0]                   mem_r [rgbhe_pkg::NUM_BINS];
  logic [rgbhe_pkg::NUM_BINS-1:0]  vld_r;
  logic [CW-1:0]                   rd_q_r;
  logic                            rd_v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v_r <= vld_r[rd_addr];
      end
    end
  end

  // a bin never written since the last clear reads as zero
  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

// ----- design/rgbhe_lane.sv -----
// one color lane: cumulative sum, incremental quotient search and map memory
// depends on rgbhe_pkg
module rgbhe_lane #(
  parameter int CW = 23
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rgbhe_pkg::lane_ctl_t         ctl,
  input  logic [CW-1:0]                total,
  input  logic [CW-1:0]                hist_data,
  input  logic [rgbhe_pkg::BIN_W-1:0]  bin,
  input  logic                         map_rd_en,
  input  logic [rgbhe_pkg::BIN_W-1:0]  map_rd_addr,
  output logic [rgbhe_pkg::BIN_W-1:0]  map_rd_data,
  output logic                         busy
);

  localparam int NW = CW + 10;

  logic [rgbhe_pkg::BIN_W-1:0] q_r;
  logic [NW-1:0]               num_r;
  logic [NW-1:0]               thr_r;
  logic                        nz_r;
  logic [NW-1:0]               dvs;
  logic [NW-1:0]               h_ext;
  logic [rgbhe_pkg::BIN_W-1:0] map_mem [rgbhe_pkg::NUM_BINS];
  logic [rgbhe_pkg::BIN_W-1:0] map_q_r;

  assign dvs   = NW'(total) << 1;
  assign h_ext = NW'(hist_data);

  // num holds 510*cum + total, thr holds 2*total*(q+1)
  assign busy = nz_r && (q_r != '1) && (thr_r <= num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r   <= '0;
      num_r <= '0;
      thr_r <= '0;
      nz_r  <= 1'b0;
    end else if (ctl.start) begin
      q_r   <= '0;
      num_r <= NW'(total);
      thr_r <= dvs;
      nz_r  <= |total;
    end else if (ctl.acc) begin
      num_r <= num_r + (h_ext << 9) - (h_ext << 1);
    end else if (ctl.step && busy) begin
      q_r   <= q_r + 1'b1;
      thr_r <= thr_r + dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      map_mem[bin] <= q_r;
    end
    if (map_rd_en) begin
      map_q_r <= map_mem[map_rd_addr];
    end
  end

  assign map_rd_data = map_q_r;

endmodule
